@@ hw/rtl/nhs_pkg.sv @@
// nhs_pkg: shared types and constants for the nameserver health selector
// no dependencies; imported by every module of the block except nhs_ram
`timescale 1ns / 1ps

package nhs_pkg;

  localparam int NS_MAX     = 8;
  localparam int PERIOD_CNT = 5;

  localparam logic [7:0] COUNT_MAX = 8'd255;
  localparam logic [7:0] PERIODS [PERIOD_CNT] = '{8'd3, 8'd9, 8'd27, 8'd81, 8'd243};

  localparam logic [1:0] CMD_PICK    = 2'd0;
  localparam logic [1:0] CMD_TIMEOUT = 2'd1;
  localparam logic [1:0] CMD_REPLY   = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] send_count;
    logic [2:0] server_index;
    logic [7:0] reachable_mask;
  } nhs_in_t;

  typedef struct packed {
    logic       found;
    logic [2:0] chosen_server;
  } nhs_out_t;

  typedef struct packed {
    logic load;
    logic count_pick;
    logic div_step;
    logic scan_init;
    logic scan_step;
    logic mem_write;
    logic result_load;
  } nhs_cmd_t;

  typedef struct packed {
    logic is_pick;
    logic is_timeout;
    logic is_reply;
    logic n_zero;
    logic div_last;
    logic scan_stop;
  } nhs_sts_t;

endpackage

@@ hw/rtl/nhs_ram.sv @@
// nhs_ram: generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module nhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/nhs_datapath.sv @@
// nhs_datapath: server count register, pick counter and residues, start
// remainder unit, timeout count store and rotated scan; uses nhs_pkg, nhs_ram
`timescale 1ns / 1ps

module nhs_datapath import nhs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  nhs_cmd_t cmd,
  output nhs_sts_t sts,
  input  nhs_in_t  in_data,
  input  logic     cfg_valid,
  input  logic [3:0] cfg_data,
  output nhs_out_t out_data
);

  logic [3:0]  server_count;
  nhs_in_t     in_r;
  logic [3:0]  n_r;
  logic [3:0]  n_in;
  logic [31:0] pick_count;
  logic [31:0] pick_count_next;
  logic [7:0]  res [PERIOD_CNT];
  logic [8:0]  dividend;
  logic [2:0]  rem;
  logic [3:0]  div_cnt;
  logic [3:0]  div_tmp;
  logic [2:0]  s_rd;
  logic [2:0]  s_ev;
  logic        ev_valid;
  logic [2:0]  ev_cnt;
  logic        found_r;
  logic [2:0]  chosen_r;
  logic        alt_v;
  logic [2:0]  alt;
  logic [NS_MAX-1:0] valid_bits;
  logic [7:0]  rdata;
  logic [2:0]  raddr;
  logic [7:0]  wdata;
  logic [7:0]  t_ev;
  logic [7:0]  t_idx;
  logic [2:0]  kidx;
  logic        reach;
  logic        hit0;
  logic        hit1;
  logic        ev_last;

  nhs_ram #(.WIDTH(8), .DEPTH(NS_MAX)) u_counts (
    .clk   (clk),
    .we    (cmd.mem_write),
    .waddr (in_r.server_index),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign n_in = (server_count > 4'(NS_MAX)) ? 4'(NS_MAX) : server_count;
  assign pick_count_next = pick_count + 32'd1;
  assign div_tmp = {rem, dividend[8]};

  assign raddr = cmd.scan_step ? s_rd : in_r.server_index;
  assign t_ev  = valid_bits[s_ev] ? rdata : 8'd0;
  assign t_idx = valid_bits[in_r.server_index] ? rdata : 8'd0;
  assign wdata = (in_r.command == CMD_TIMEOUT) ?
                 ((t_idx == COUNT_MAX) ? COUNT_MAX : t_idx + 8'd1) : 8'd0;

  assign kidx  = (t_ev >= 8'd5) ? 3'd4 : (t_ev[2:0] - 3'd1);
  assign reach = in_r.reachable_mask[s_ev];
  assign hit0  = reach && ((t_ev == 8'd0) || (res[kidx] == 8'd0));
  assign hit1  = reach && (t_ev != 8'd0);
  assign ev_last = ({1'b0, ev_cnt} == (n_r - 4'd1));

  assign sts.is_pick    = (in_r.command == CMD_PICK);
  assign sts.is_timeout = (in_r.command == CMD_TIMEOUT);
  assign sts.is_reply   = (in_r.command == CMD_REPLY);
  assign sts.n_zero     = (n_r == 4'd0);
  assign sts.div_last   = (div_cnt == 4'd8);
  assign sts.scan_stop  = ev_valid && (hit0 || ev_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      server_count <= 4'd1;
      pick_count   <= 32'd0;
      valid_bits   <= '0;
      for (int k = 0; k < PERIOD_CNT; k++) begin
        res[k] <= 8'd0;
      end
    end else begin
      if (cfg_valid) begin
        server_count <= cfg_data;
      end
      if (cmd.count_pick) begin
        pick_count <= pick_count_next;
        for (int k = 0; k < PERIOD_CNT; k++) begin
          if (pick_count_next == 32'd0 || res[k] == PERIODS[k] - 8'd1) begin
            res[k] <= 8'd0;
          end else begin
            res[k] <= res[k] + 8'd1;
          end
        end
      end
      if (cmd.mem_write) begin
        valid_bits[in_r.server_index] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r     <= in_data;
      n_r      <= n_in;
      dividend <= {1'b0, in_data.send_count} + {5'd0, n_in} - 9'd1;
      rem      <= 3'd0;
      div_cnt  <= 4'd0;
      found_r  <= 1'b0;
      chosen_r <= 3'd0;
      alt_v    <= 1'b0;
      alt      <= 3'd0;
    end
    if (cmd.div_step) begin
      if (div_tmp >= n_r) begin
        rem <= 3'(div_tmp - n_r);
      end else begin
        rem <= div_tmp[2:0];
      end
      dividend <= {dividend[7:0], 1'b0};
      div_cnt  <= div_cnt + 4'd1;
    end
    if (cmd.scan_init) begin
      s_rd     <= rem;
      ev_valid <= 1'b0;
      ev_cnt   <= 3'd0;
    end
    if (cmd.scan_step) begin
      s_ev     <= s_rd;
      ev_valid <= 1'b1;
      s_rd     <= ({1'b0, s_rd} + 4'd1 == n_r) ? 3'd0 : s_rd + 3'd1;
      if (ev_valid) begin
        ev_cnt <= ev_cnt + 3'd1;
        if (hit0) begin
          found_r  <= 1'b1;
          chosen_r <= s_ev;
        end else if (hit1 && !alt_v) begin
          alt_v <= 1'b1;
          alt   <= s_ev;
        end
      end
    end
    if (cmd.result_load) begin
      out_data.found         <= found_r || alt_v;
      out_data.chosen_server <= found_r ? chosen_r : (alt_v ? alt : 3'd0);
    end
  end

endmodule

@@ hw/rtl/nhs_ctrl.sv @@
// nhs_ctrl: sequencing state machine and output handshake
// uses nhs_pkg command and status types
`timescale 1ns / 1ps

module nhs_ctrl import nhs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  nhs_sts_t sts,
  output nhs_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_DECODE    = 3'd1;
  localparam logic [2:0] ST_DIV       = 3'd2;
  localparam logic [2:0] ST_SCAN_INIT = 3'd3;
  localparam logic [2:0] ST_SCAN      = 3'd4;
  localparam logic [2:0] ST_UPD_RD    = 3'd5;
  localparam logic [2:0] ST_UPD_WR    = 3'd6;
  localparam logic [2:0] ST_FINISH    = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       slot_free;

  assign in_ready  = (state == ST_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.is_pick) begin
          cmd.count_pick = 1'b1;
          state_next     = sts.n_zero ? ST_FINISH : ST_DIV;
        end else if (sts.is_timeout) begin
          state_next = ST_UPD_RD;
        end else if (sts.is_reply) begin
          state_next = ST_UPD_WR;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_SCAN_INIT;
        end
      end
      ST_SCAN_INIT: begin
        cmd.scan_init = 1'b1;
        state_next    = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_stop) begin
          state_next = ST_FINISH;
        end
      end
      ST_UPD_RD: begin
        state_next = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        cmd.mem_write = 1'b1;
        state_next    = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd.result_load = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.result_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/nameserver_health_selector.sv @@
// nameserver_health_selector: top level, joins controller and datapath
// uses nhs_pkg, nhs_ctrl, nhs_datapath
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_data   (nhs_in_t)
//   out      output     out_valid / out_ready  out_data  (nhs_out_t)
//   cfg      input      cfg_valid / cfg_ready  cfg_data  (server count, 4 bits)
//
// one transaction at a time; a pick runs DECODE, the 9-step start remainder, scan init and
// a scan of up to n servers (n = servers in use), one server per scan cycle, then FINISH
// a timeout reads then writes its count, a reply clears it, others and no-server picks go to FINISH; the
// timeout counts sit in an 8-entry ram with one read port, so the scan reads one server per cycle
// rst is synchronous; counts read as zero until first written, no clearing pass
// a finished result waits in the output register while the next transaction is taken;
// the block holds in FINISH only if that register is still full
`timescale 1ns / 1ps

module nameserver_health_selector import nhs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  nhs_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output nhs_out_t   out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data
);

  nhs_cmd_t cmd;
  nhs_sts_t sts;

  assign cfg_ready = 1'b1;

  nhs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  nhs_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("transaction accepted while another is in progress");

  a_result_needs_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result produced without a transaction in progress");

  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.chosen_server == 3'd0)
    else $error("nonzero server reported with nothing found");

  a_load_on_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |-> !out_valid || out_ready)
    else $error("result overwrote a pending output");

endmodule
